// File: rtl/mfpc_pkg.sv
// package for the magazine free-pointer cache
// holds field widths, request and result structs, status and register codes
// no dependencies
package mfpc_pkg;

  // fixed field widths of the request, result and configuration channels
  localparam int REQ_W        = 2;
  localparam int ADDR_FIELD_W = 32;
  localparam int ARG_W        = 32;
  localparam int CFG_W        = 17;
  localparam int CFG_IDX_W    = 2;

  // parameter defaults for the top level
  localparam int DEF_NUM_REQUESTERS = 4;
  localparam int DEF_ROUNDS         = 16;
  localparam int DEF_NUM_FRAMES     = 16;
  localparam int DEF_ADDR_WIDTH     = 32;

  // register values after reset
  localparam logic [CFG_W-1:0] RST_OBJECT_SIZE   = 17'd64;
  localparam logic [CFG_W-1:0] RST_MAX_ALIGN     = 17'd8;
  localparam logic             RST_GROWTH_ENABLE = 1'b1;

  // request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBJECT_SIZE   = 2'd0,
    CFG_MAX_ALIGN     = 2'd1,
    CFG_GROWTH_ENABLE = 2'd2
  } mfpc_cfg_idx_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_SERVED    = 3'd0,
    ST_FWD_ALLOC = 3'd1,
    ST_FWD_FREE  = 3'd2,
    ST_NULL      = 3'd3,
    ST_BAD       = 3'd4
  } mfpc_status_t;

  // one request
  typedef struct packed {
    logic                    operation;
    logic [REQ_W-1:0]        requester;
    logic [ADDR_FIELD_W-1:0] object_address;
    logic [ARG_W-1:0]        request_size;
    logic [ARG_W-1:0]        request_align;
    logic [ARG_W-1:0]        request_phase;
  } mfpc_in_t;

  // one result
  typedef struct packed {
    mfpc_status_t            status;
    logic [ADDR_FIELD_W-1:0] result_address;
    logic                    frame_added;
  } mfpc_out_t;

  // operation on one depot stack
  typedef struct packed {
    logic push;
    logic pop;
  } mfpc_stack_op_t;

endpackage

// File: rtl/mfpc_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module mfpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/mfpc_stack.sv
// lifo stack of magazine frame ids for the depot
// top entry lives in a register, the rest in an mfpc_ram; uses mfpc_pkg
module mfpc_stack #(
  parameter int NUM_FRAMES = mfpc_pkg::DEF_NUM_FRAMES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mfpc_pkg::mfpc_stack_op_t          op,
  input  logic [$clog2(NUM_FRAMES)-1:0]     push_id,
  output logic [$clog2(NUM_FRAMES+1)-1:0]   count,
  output logic [$clog2(NUM_FRAMES)-1:0]     top
);
  import mfpc_pkg::*;

  localparam int IW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES+1);

  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] top_r, top_nxt;
  logic          push_ok;
  logic [IW-1:0] raddr;
  logic [IW-1:0] second;

  // push is dropped when the stack already holds every frame
  assign push_ok = op.push && (count_r < CW'(NUM_FRAMES));

  // next count and top; the entry below the top is always being read
  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = push_id;
    end else if (op.pop) begin
      count_nxt = count_r - CW'(1);
      top_nxt   = second;
    end
  end

  // read address tracks the second entry of the next stack contents
  assign raddr = IW'(count_nxt - CW'(2));

  mfpc_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (count_r[IW-1:0]),
    .wdata (push_id),
    .re    (1'b1),
    .raddr (raddr),
    .rdata (second)
  );

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // top register
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  assign count = count_r;
  assign top   = top_r;

endmodule

// File: rtl/magazine_free_pointer_cache_unit.sv
// top level of the magazine free-pointer cache
// uses mfpc_pkg, mfpc_ram (round store) and mfpc_stack (full and empty depot stacks)
//
// Takes one allocate or free request per clock while in_stall is low and returns
// exactly one result per request, in order. A request is accepted into an input
// register and decided from there (magazine swap, depot exchange, round store
// access); the decision is registered in the result stage, and the result is then
// loaded into the output register once the round store's registered read data is back.
// Sustained rate is one request per cycle; a stalled output holds the pipeline. The
// round store and depot stacks need no clearing pass after reset. Configuration writes
// are always taken (cfg_ready is high) and must only be issued while no request is in
// flight.
module magazine_free_pointer_cache_unit #(
  parameter int NUM_REQUESTERS = mfpc_pkg::DEF_NUM_REQUESTERS,
  parameter int ROUNDS         = mfpc_pkg::DEF_ROUNDS,
  parameter int NUM_FRAMES     = mfpc_pkg::DEF_NUM_FRAMES,
  parameter int ADDR_WIDTH     = mfpc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mfpc_pkg::mfpc_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mfpc_pkg::mfpc_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mfpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mfpc_pkg::CFG_W-1:0]       cfg_data
);
  import mfpc_pkg::*;

  // requester field reaches at most four slots
  localparam int REQ_CODES = 1 << REQ_W;
  localparam int REQ_SLOTS = (NUM_REQUESTERS < REQ_CODES) ? NUM_REQUESTERS : REQ_CODES;
  localparam int RIW       = (REQ_SLOTS > 1) ? $clog2(REQ_SLOTS) : 1;
  localparam int IW        = $clog2(NUM_FRAMES);
  localparam int CW        = $clog2(NUM_FRAMES+1);
  localparam int FW        = $clog2(ROUNDS+1);
  localparam int DEPTH     = NUM_FRAMES * ROUNDS;
  localparam int RAW       = $clog2(DEPTH);
  localparam int DW        = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;

  // configuration registers
  logic [CFG_W-1:0] obj_size_r;
  logic [CFG_W-1:0] max_align_r;
  logic             growth_r;

  // input stage
  logic     a_valid_r;
  mfpc_in_t a_r;

  // per-requester magazines
  logic [IW-1:0] lid_r [REQ_SLOTS];
  logic          lv_r  [REQ_SLOTS];
  logic [FW-1:0] lf_r  [REQ_SLOTS];
  logic [IW-1:0] pid_r [REQ_SLOTS];
  logic          pv_r  [REQ_SLOTS];
  logic [FW-1:0] pf_r  [REQ_SLOTS];

  logic [CW-1:0] fresh_r, fresh_nxt;

  // result stage waiting on round store read data
  logic         b_valid_r;
  mfpc_status_t b_status_r;
  logic [DW-1:0] b_addr_r;
  logic         b_added_r;
  logic         b_use_ram_r;

  // output register
  logic      out_valid_r;
  mfpc_out_t out_r;

  // handshake
  logic out_free, b_adv, b_free, a_fire, in_acc;

  // decision signals
  logic [REQ_W-1:0] req_wrap;
  logic [RIW-1:0]   ridx;
  logic [DW-1:0]    addr_m;
  logic [IW-1:0]    lid, pid;
  logic             lv, pv;
  logic [FW-1:0]    lf, pf;
  mfpc_status_t     st;
  logic [DW-1:0]    res_addr;
  logic             use_ram, added;
  logic             ram_we, ram_re, mag_we;
  logic [IW-1:0]    slot_id;
  logic [FW-1:0]    slot_fill;
  logic [RAW-1:0]   slot;
  logic [IW-1:0]    lid_nxt, pid_nxt;
  logic             lv_nxt, pv_nxt;
  logic [FW-1:0]    lf_nxt, pf_nxt;
  mfpc_stack_op_t   full_op, empty_op;
  logic [IW-1:0]    empty_push_id;
  logic [CW-1:0]    full_cnt, empty_cnt;
  logic [IW-1:0]    full_top, empty_top;
  logic [DW-1:0]    rd_data;
  logic             size_ok;

  // pipeline flow
  assign out_free  = !out_valid_r || !out_stall;
  assign b_adv     = b_valid_r && out_free;
  assign b_free    = !b_valid_r || b_adv;
  assign a_fire    = a_valid_r && b_free;
  assign in_stall  = a_valid_r && !b_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_size_r  <= RST_OBJECT_SIZE;
      max_align_r <= RST_MAX_ALIGN;
      growth_r    <= RST_GROWTH_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OBJECT_SIZE:   obj_size_r  <= cfg_data;
        CFG_MAX_ALIGN:     max_align_r <= cfg_data;
        CFG_GROWTH_ENABLE: growth_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r <= in_data;
    end
  end

  // requester index wraps modulo the requester count
  always_comb begin
    req_wrap = a_r.requester;
    for (int k = 0; k < REQ_CODES - 1; k++) begin
      if (int'(req_wrap) >= NUM_REQUESTERS) begin
        req_wrap = req_wrap - REQ_W'(NUM_REQUESTERS);
      end
    end
  end

  assign ridx   = RIW'(req_wrap);
  assign addr_m = a_r.object_address[DW-1:0];
  assign lid    = lid_r[ridx];
  assign lv     = lv_r[ridx];
  assign lf     = lf_r[ridx];
  assign pid    = pid_r[ridx];
  assign pv     = pv_r[ridx];
  assign pf     = pf_r[ridx];
  assign size_ok = (a_r.request_size == ARG_W'(obj_size_r));

  // allocate and free decision
  always_comb begin
    st            = ST_SERVED;
    res_addr      = addr_m;
    use_ram       = 1'b0;
    added         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    mag_we        = 1'b0;
    slot_id       = lid;
    slot_fill     = lf;
    lid_nxt       = lid;
    lv_nxt        = lv;
    lf_nxt        = lf;
    pid_nxt       = pid;
    pv_nxt        = pv;
    pf_nxt        = pf;
    full_op       = '0;
    empty_op      = '0;
    empty_push_id = pid;
    fresh_nxt     = fresh_r;

    if (a_r.operation == OP_ALLOC) begin
      res_addr = '0;
      if (!size_ok || (a_r.request_align > ARG_W'(max_align_r)) ||
          (a_r.request_phase != '0)) begin
        st = ST_BAD;
      end else if (lv && (lf != '0)) begin
        // pop from the loaded magazine
        use_ram   = 1'b1;
        ram_re    = 1'b1;
        mag_we    = 1'b1;
        lf_nxt    = lf - FW'(1);
        slot_fill = lf - FW'(1);
      end else if (pv && (pf != '0)) begin
        // previous magazine has rounds: swap, then pop
        use_ram   = 1'b1;
        ram_re    = 1'b1;
        mag_we    = 1'b1;
        lid_nxt   = pid;
        lv_nxt    = pv;
        lf_nxt    = pf - FW'(1);
        pid_nxt   = lid;
        pv_nxt    = lv;
        pf_nxt    = lf;
        slot_id   = pid;
        slot_fill = pf - FW'(1);
      end else if (full_cnt == '0) begin
        st = ST_FWD_ALLOC;
      end else begin
        // exchange with a full magazine from the depot
        use_ram      = 1'b1;
        ram_re       = 1'b1;
        mag_we       = 1'b1;
        full_op.pop  = 1'b1;
        empty_op.push = pv;
        lid_nxt      = full_top;
        lv_nxt       = 1'b1;
        lf_nxt       = FW'(ROUNDS - 1);
        pid_nxt      = lid;
        pv_nxt       = lv;
        pf_nxt       = lf;
        slot_id      = full_top;
        slot_fill    = FW'(ROUNDS - 1);
      end
    end else if (addr_m == '0) begin
      st       = ST_NULL;
      res_addr = '0;
    end else if (!size_ok) begin
      st = ST_BAD;
    end else if (lv && (lf < FW'(ROUNDS))) begin
      // push into the loaded magazine
      ram_we = 1'b1;
      mag_we = 1'b1;
      lf_nxt = lf + FW'(1);
    end else if (pv && (pf < FW'(ROUNDS))) begin
      // previous magazine has room: swap, then push
      ram_we    = 1'b1;
      mag_we    = 1'b1;
      lid_nxt   = pid;
      lv_nxt    = pv;
      lf_nxt    = pf + FW'(1);
      pid_nxt   = lid;
      pv_nxt    = lv;
      pf_nxt    = lf;
      slot_id   = pid;
      slot_fill = pf;
    end else if (empty_cnt == '0) begin
      // forward the free, maybe grow the depot with a fresh frame
      st = ST_FWD_FREE;
      if (growth_r && (fresh_r < CW'(NUM_FRAMES))) begin
        empty_op.push = 1'b1;
        empty_push_id = fresh_r[IW-1:0];
        fresh_nxt     = fresh_r + CW'(1);
        added         = 1'b1;
      end
    end else begin
      // exchange with an empty magazine from the depot
      ram_we        = 1'b1;
      mag_we        = 1'b1;
      empty_op.pop  = 1'b1;
      full_op.push  = pv;
      lid_nxt       = empty_top;
      lv_nxt        = 1'b1;
      lf_nxt        = FW'(1);
      pid_nxt       = lid;
      pv_nxt        = lv;
      pf_nxt        = lf;
      slot_id       = empty_top;
      slot_fill     = '0;
    end
  end

  // round store address of one round
  assign slot = RAW'(slot_id) * RAW'(ROUNDS) + RAW'(slot_fill);

  // round store
  mfpc_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_rounds (
    .clk   (clk),
    .we    (a_fire && ram_we),
    .waddr (slot),
    .wdata (addr_m),
    .re    (a_fire && ram_re),
    .raddr (slot),
    .rdata (rd_data)
  );

  // depot stacks
  mfpc_stack #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_full (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (a_fire ? full_op : mfpc_stack_op_t'('0)),
    .push_id (pid),
    .count   (full_cnt),
    .top     (full_top)
  );

  mfpc_stack #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_empty (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (a_fire ? empty_op : mfpc_stack_op_t'('0)),
    .push_id (empty_push_id),
    .count   (empty_cnt),
    .top     (empty_top)
  );

  // magazine state and fresh frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REQ_SLOTS; i++) begin
        lid_r[i] <= '0;
        lv_r[i]  <= 1'b0;
        lf_r[i]  <= '0;
        pid_r[i] <= '0;
        pv_r[i]  <= 1'b0;
        pf_r[i]  <= '0;
      end
      fresh_r <= '0;
    end else if (a_fire) begin
      if (mag_we) begin
        lid_r[ridx] <= lid_nxt;
        lv_r[ridx]  <= lv_nxt;
        lf_r[ridx]  <= lf_nxt;
        pid_r[ridx] <= pid_nxt;
        pv_r[ridx]  <= pv_nxt;
        pf_r[ridx]  <= pf_nxt;
      end
      fresh_r <= fresh_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_fire) begin
      b_valid_r <= 1'b1;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_status_r  <= st;
      b_addr_r    <= res_addr;
      b_added_r   <= added;
      b_use_ram_r <= use_ram;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_r.status         <= b_status_r;
      out_r.result_address <= ADDR_FIELD_W'(b_use_ram_r ? rd_data : b_addr_r);
      out_r.frame_added    <= b_added_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a fresh frame is only ever added by a forwarded free
  a_added_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_added |-> out_data.status == ST_FWD_FREE)
    else $error("frame added on a result that is not a forwarded free");

  // depot never holds more frames than were created
  a_depot_frames: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, full_cnt} + {1'b0, empty_cnt}) <= {1'b0, fresh_r})
    else $error("depot holds more frames than were created");

  // fresh frame counter stays within the pool
  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CW'(NUM_FRAMES))
    else $error("fresh frame counter beyond the pool");

  // an accepted request is held in the input register
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> a_valid_r)
    else $error("accepted request lost from the input register");

  // round store read data holds while a popped result waits
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_use_ram_r && !b_adv |=> b_valid_r && $stable(rd_data))
    else $error("round store data changed under a waiting result");

endmodule
